// File: src/hsl2rgb_pkg.sv
package hsl2rgb_pkg;

	// Piece of the HSL channel curve that a shifted hue falls in.
	typedef enum logic [1:0] {
		SEG_RISE,
		SEG_FLAT,
		SEG_FALL,
		SEG_LOW
	} hsl2rgb_seg_t;

	// Load enables for the per-channel back end of the pipeline.
	typedef struct packed {
		logic s5;
		logic s6;
		logic s7;
		logic s8;
	} hsl2rgb_en_t;

	// Input range limits.
	localparam int unsigned HUE_FULL = 360;
	localparam int unsigned PCT_FULL = 100;

endpackage

// File: src/hsl2rgb_chan.sv
module hsl2rgb_chan #(
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  hsl2rgb_pkg::hsl2rgb_en_t en,
	input  logic [FRAC_BITS:0]       t,
	input  logic [FRAC_BITS:0]       p,
	input  logic [FRAC_BITS:0]       q,
	input  logic [FRAC_BITS:0]       d,
	output logic [7:0]               level
);

	localparam int W1    = FRAC_BITS + 1;
	localparam int W2    = 2 * W1;
	localparam int unsigned ONE   = 1 << FRAC_BITS;
	localparam int unsigned HALF  = ONE / 2;
	localparam int unsigned SIXTH = (ONE + 3) / 6;
	localparam int unsigned TWO3  = (2 * ONE + 1) / 3;

	hsl2rgb_pkg::hsl2rgb_seg_t mode_n, mode_s5, mode_s6;
	logic [W1-1:0]   a_n, a_s5;
	logic [W1-1:0]   fspan;
	logic [W1+1:0]   six_t, six_f;
	logic [W1-1:0]   p_s5, q_s5, d_s5, p_s6, q_s6;
	logic [W2-1:0]   prod_s6, rsum;
	logic [W1+1:0]   seg_sum;
	logic [W1-1:0]   v_n, v_s7;
	logic [W1+7:0]   scaled;
	logic [7:0]      level_s8;

	// Slope operand: six times the distance into the rising or falling piece.
	assign fspan = W1'(TWO3) - t;
	assign six_t = {t, 2'b00} + {1'b0, t, 1'b0};
	assign six_f = {fspan, 2'b00} + {1'b0, fspan, 1'b0};

	always_comb begin
		mode_n = hsl2rgb_pkg::SEG_LOW;
		a_n    = '0;
		if (t < W1'(SIXTH)) begin
			mode_n = hsl2rgb_pkg::SEG_RISE;
			a_n    = six_t[W1-1:0];
		end else if (t < W1'(HALF)) begin
			mode_n = hsl2rgb_pkg::SEG_FLAT;
		end else if (t < W1'(TWO3)) begin
			mode_n = hsl2rgb_pkg::SEG_FALL;
			a_n    = six_f[W1-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			mode_s5 <= mode_n;
			a_s5    <= a_n;
			p_s5    <= p;
			q_s5    <= q;
			d_s5    <= d;
		end
		if (en.s6) begin
			mode_s6 <= mode_s5;
			prod_s6 <= W2'(d_s5) * W2'(a_s5);
			p_s6    <= p_s5;
			q_s6    <= q_s5;
		end
		if (en.s7) begin
			v_s7 <= v_n;
		end
		if (en.s8) begin
			level_s8 <= scaled[W1+6:W1-1];
		end
	end

	assign rsum    = prod_s6 + W2'(HALF);
	assign seg_sum = (W1+2)'(p_s6) + (W1+2)'(rsum[W2-1:FRAC_BITS]);

	always_comb begin
		unique case (mode_s6) inside
			hsl2rgb_pkg::SEG_RISE,
			hsl2rgb_pkg::SEG_FALL: begin
				if (seg_sum > (W1+2)'(ONE)) begin
					v_n = W1'(ONE);
				end else begin
					v_n = seg_sum[W1-1:0];
				end
			end
			hsl2rgb_pkg::SEG_FLAT: v_n = q_s6;
			hsl2rgb_pkg::SEG_LOW:  v_n = p_s6;
			default:               v_n = p_s6;
		endcase
	end

	// Byte = round(v * 255 / ONE); v never exceeds ONE, so no cap is needed.
	assign scaled = {v_s7, 8'h00} - (W1+8)'(v_s7) + (W1+8)'(HALF);

	assign level = level_s8;

endmodule

// File: src/hsl_to_rgb_converter.sv
// HSLA to RGBA color converter, one pixel per clock while rgb_stall is low.
// The request channel (hsl_valid, hsl_stall) carries hue in whole degrees,
// saturation and lightness in whole percent, and an alpha byte. A request is
// taken at a rising edge where hsl_valid is high and hsl_stall is low.
// The result channel (rgb_valid, rgb_stall) returns red, green and blue as
// bytes equal to round(value * 255), and alpha_out equal to alpha_in.
// Out-of-range hues wrap by 360, and saturation or lightness above 100 are
// treated as 100.
// The datapath is an eight-stage pipeline in unsigned fixed point with
// FRAC_BITS fraction bits. A result shows on the outputs once it reaches
// the last stage and leaves at the first rising edge with rgb_stall low;
// a new request can be taken every cycle while rgb_stall stays low.
// Each stage has its own valid bit and loads when it is empty or when the
// stage after it loads, so a stall on rgb_stall holds the full stages while
// empty stages keep filling; hsl_stall rises only once every stage is full.
// Nothing is dropped or repeated under stall.
// Reset (arst_n low) empties the pipeline at once; no results are pending
// afterwards and the block takes requests in the first cycle after reset.
module hsl_to_rgb_converter #(
	parameter int FRAC_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       hsl_valid,
	output logic       hsl_stall,
	input  logic [8:0] hue,
	input  logic [6:0] saturation,
	input  logic [6:0] lightness,
	input  logic [7:0] alpha_in,
	output logic       rgb_valid,
	input  logic       rgb_stall,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic [7:0] alpha_out
);

	localparam int W1 = FRAC_BITS + 1;
	localparam int W2 = 2 * W1;
	localparam int FS = FRAC_BITS + 4;
	localparam int unsigned ONE   = 1 << FRAC_BITS;
	localparam int unsigned HALF  = ONE / 2;
	localparam int unsigned THIRD = (ONE + 1) / 3;

	// Hue scale: round(hue * ONE / 360) = floor((hue * ONE + 180) / 8 / 45).
	// Percent scale: round(x * ONE / 100) = floor((x * ONE + 50) / 4 / 25).
	// Both divisions by the odd factor use a reciprocal multiply that can
	// come out one low, followed by a single remainder check.
	localparam int unsigned DIV_H = 45;
	localparam int unsigned DIV_P = 25;
	localparam int MH_W = FRAC_BITS + 6;
	localparam int KH_W = FRAC_BITS + 7;
	localparam int PH_W = MH_W + KH_W;
	localparam int SH   = FRAC_BITS + 12;
	localparam int MP_W = FRAC_BITS + 5;
	localparam int KP_W = FRAC_BITS + 6;
	localparam int PP_W = MP_W + KP_W;
	localparam int SP   = FRAC_BITS + 10;
	localparam logic [63:0] KH_FULL = (64'd1 << SH) / 64'(DIV_H);
	localparam logic [63:0] KP_FULL = (64'd1 << SP) / 64'(DIV_P);
	localparam logic [KH_W-1:0] KH = KH_W'(KH_FULL);
	localparam logic [KP_W-1:0] KP = KP_W'(KP_FULL);

	// Stage enables and valid bits.
	logic en1, en2, en3, en4, en5, en6, en7, en8;
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic valid_s5, valid_s6, valid_s7, valid_s8;

	assign en8 = !valid_s8 || !rgb_stall;
	assign en7 = !valid_s7 || en8;
	assign en6 = !valid_s6 || en7;
	assign en5 = !valid_s5 || en6;
	assign en4 = !valid_s4 || en5;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;

	assign hsl_stall = !en1;
	assign rgb_valid = valid_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= hsl_valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
			if (en5) valid_s5 <= valid_s4;
			if (en6) valid_s6 <= valid_s5;
			if (en7) valid_s7 <= valid_s6;
			if (en8) valid_s8 <= valid_s7;
		end
	end

	// Stage 1: range fixes, scaled numerators, reciprocal products.
	logic [8:0]           hue_w;
	logic [6:0]           sat_c, lig_c;
	logic [FRAC_BITS+8:0] num_h;
	logic [FRAC_BITS+6:0] num_s, num_l;
	logic [MH_W-1:0]      mh, mh_s1;
	logic [MP_W-1:0]      ms, ml, ms_s1, ml_s1;
	logic [PH_W-1:0]      ph_s1;
	logic [PP_W-1:0]      ps_s1, pl_s1;
	logic                 zero_s1;
	logic [7:0]           alpha_s1;

	assign hue_w = (hue >= 9'(hsl2rgb_pkg::HUE_FULL)) ?
		hue - 9'(hsl2rgb_pkg::HUE_FULL) : hue;
	assign sat_c = (saturation > 7'(hsl2rgb_pkg::PCT_FULL)) ?
		7'(hsl2rgb_pkg::PCT_FULL) : saturation;
	assign lig_c = (lightness > 7'(hsl2rgb_pkg::PCT_FULL)) ?
		7'(hsl2rgb_pkg::PCT_FULL) : lightness;

	assign num_h = {hue_w, {FRAC_BITS{1'b0}}} + (FRAC_BITS+9)'(hsl2rgb_pkg::HUE_FULL / 2);
	assign num_s = {sat_c, {FRAC_BITS{1'b0}}} + (FRAC_BITS+7)'(hsl2rgb_pkg::PCT_FULL / 2);
	assign num_l = {lig_c, {FRAC_BITS{1'b0}}} + (FRAC_BITS+7)'(hsl2rgb_pkg::PCT_FULL / 2);
	assign mh    = num_h[FRAC_BITS+8:3];
	assign ms    = num_s[FRAC_BITS+6:2];
	assign ml    = num_l[FRAC_BITS+6:2];

	always_ff @(posedge clk) begin
		if (en1) begin
			mh_s1    <= mh;
			ms_s1    <= ms;
			ml_s1    <= ml;
			ph_s1    <= PH_W'(mh) * PH_W'(KH);
			ps_s1    <= PP_W'(ms) * PP_W'(KP);
			pl_s1    <= PP_W'(ml) * PP_W'(KP);
			zero_s1  <= (sat_c == 7'd0);
			alpha_s1 <= alpha_in;
		end
	end

	// Stage 2: quotient correction gives h, s and l.
	logic [FRAC_BITS-1:0] hq0, h_n, h_s2;
	logic [W1-1:0]        sq0, lq0, s_n, l_n, s_s2, l_s2;
	logic [MH_W-1:0]      hrem;
	logic [MP_W-1:0]      srem, lrem;
	logic                 zero_s2;
	logic [7:0]           alpha_s2;

	assign hq0  = ph_s1[SH +: FRAC_BITS];
	assign sq0  = ps_s1[SP +: W1];
	assign lq0  = pl_s1[SP +: W1];
	assign hrem = mh_s1 - MH_W'(MH_W'(hq0) * MH_W'(DIV_H));
	assign srem = ms_s1 - MP_W'(MP_W'(sq0) * MP_W'(DIV_P));
	assign lrem = ml_s1 - MP_W'(MP_W'(lq0) * MP_W'(DIV_P));
	assign h_n  = (hrem >= MH_W'(DIV_H)) ? hq0 + 1'b1 : hq0;
	assign s_n  = (srem >= MP_W'(DIV_P)) ? sq0 + 1'b1 : sq0;
	assign l_n  = (lrem >= MP_W'(DIV_P)) ? lq0 + 1'b1 : lq0;

	always_ff @(posedge clk) begin
		if (en2) begin
			h_s2     <= h_n;
			s_s2     <= s_n;
			l_s2     <= l_n;
			zero_s2  <= zero_s1;
			alpha_s2 <= alpha_s1;
		end
	end

	// Stage 3: product of lightness and saturation.
	logic [FRAC_BITS-1:0] h_s3;
	logic [W1-1:0]        s_s3, l_s3;
	logic [W2-1:0]        ls_s3;
	logic                 zero_s3;
	logic [7:0]           alpha_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			h_s3     <= h_s2;
			s_s3     <= s_s2;
			l_s3     <= l_s2;
			ls_s3    <= W2'(l_s2) * W2'(s_s2);
			zero_s3  <= zero_s2;
			alpha_s3 <= alpha_s2;
		end
	end

	// Stage 4: q, p, their spread, and the three shifted hues. With zero
	// saturation q and p both take the lightness, which makes every channel
	// equal to it.
	logic [W2-1:0]        ls_rnd;
	logic signed [FS-1:0] l_x, s_x, r_x, q_raw, p_raw;
	logic [W1-1:0]        q_c, p_c, q_n, p_n;
	logic [W1-1:0]        t1_sum, t1_n, t3_n;
	logic [W1-1:0]        q_s4, p_s4, d_s4, t1_s4, t2_s4, t3_s4;
	logic [7:0]           alpha_s4;

	assign ls_rnd = ls_s3 + W2'(HALF);
	assign l_x    = signed'(FS'(l_s3));
	assign s_x    = signed'(FS'(s_s3));
	assign r_x    = signed'(FS'(ls_rnd[W2-1:FRAC_BITS]));
	assign q_raw  = (l_s3 < W1'(HALF)) ? l_x + r_x : l_x + s_x - r_x;
	assign p_raw  = (l_x <<< 1) - signed'(FS'(q_c));

	always_comb begin
		if (q_raw < 0) begin
			q_c = '0;
		end else if (q_raw > signed'(FS'(ONE))) begin
			q_c = W1'(ONE);
		end else begin
			q_c = W1'(unsigned'(q_raw));
		end
		if (p_raw < 0) begin
			p_c = '0;
		end else if (p_raw > signed'(FS'(ONE))) begin
			p_c = W1'(ONE);
		end else begin
			p_c = W1'(unsigned'(p_raw));
		end
	end

	assign q_n = zero_s3 ? l_s3 : q_c;
	assign p_n = zero_s3 ? l_s3 : p_c;

	// Red is shifted up a third and wraps only above one; blue is shifted
	// down a third and wraps when it would go negative.
	assign t1_sum = W1'(h_s3) + W1'(THIRD);
	assign t1_n   = (t1_sum > W1'(ONE)) ? t1_sum - W1'(ONE) : t1_sum;
	assign t3_n   = (h_s3 < FRAC_BITS'(THIRD)) ?
		W1'(h_s3) + W1'(ONE - THIRD) : W1'(h_s3) - W1'(THIRD);

	always_ff @(posedge clk) begin
		if (en4) begin
			q_s4     <= q_n;
			p_s4     <= p_n;
			d_s4     <= q_n - p_n;
			t1_s4    <= t1_n;
			t2_s4    <= W1'(h_s3);
			t3_s4    <= t3_n;
			alpha_s4 <= alpha_s3;
		end
	end

	// Stages 5 to 8: one curve unit per color channel.
	hsl2rgb_pkg::hsl2rgb_en_t chan_en;
	logic [7:0] alpha_s5, alpha_s6, alpha_s7, alpha_s8;

	assign chan_en = '{s5: en5, s6: en6, s7: en7, s8: en8};

	hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_red (
		.clk   (clk),
		.en    (chan_en),
		.t     (t1_s4),
		.p     (p_s4),
		.q     (q_s4),
		.d     (d_s4),
		.level (red)
	);

	hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_green (
		.clk   (clk),
		.en    (chan_en),
		.t     (t2_s4),
		.p     (p_s4),
		.q     (q_s4),
		.d     (d_s4),
		.level (green)
	);

	hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_blue (
		.clk   (clk),
		.en    (chan_en),
		.t     (t3_s4),
		.p     (p_s4),
		.q     (q_s4),
		.d     (d_s4),
		.level (blue)
	);

	// Alpha rides alongside the color stages unchanged.
	always_ff @(posedge clk) begin
		if (en5) alpha_s5 <= alpha_s4;
		if (en6) alpha_s6 <= alpha_s5;
		if (en7) alpha_s7 <= alpha_s6;
		if (en8) alpha_s8 <= alpha_s7;
	end

	assign alpha_out = alpha_s8;

endmodule

// File: tb/sv/hsl_to_rgb_converter_tb.sv
module hsl_to_rgb_converter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Fixed-point format of the color datapath. The constants below mirror the
	// rounding of the hardware: one third and one sixth round to nearest.
	localparam int FRAC_BITS = 16;
	localparam longint ONE_FX = longint'(1) << FRAC_BITS;
	localparam longint HALF_FX = ONE_FX / 2;
	localparam longint THIRD_FX = (ONE_FX + 1) / 3;
	localparam longint SIXTH_FX = (ONE_FX + 3) / 6;
	localparam longint TWOTHIRDS_FX = (2 * ONE_FX + 1) / 3;
	localparam longint HUE_SPAN = hsl2rgb_pkg::HUE_FULL;
	localparam longint PCT_SPAN = hsl2rgb_pkg::PCT_FULL;

	// The pipeline is eight stages deep; the tail wait and the watchdog are
	// sized from that and from the longest receiver hold-off.
	localparam int PIPE_DEPTH = 8;
	localparam int HOLD_CYCLES = 200;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int MAX_PRINTED = 100;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} rgba_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       hsl_valid = 1'b0;
	logic       hsl_stall;
	logic [8:0] hue = '0;
	logic [6:0] saturation = '0;
	logic [6:0] lightness = '0;
	logic [7:0] alpha_in = '0;
	logic       rgb_valid;
	logic       rgb_stall = 1'b0;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha_out;

	// Pixels that the block has taken and whose RGBA result is still owed,
	// oldest first.
	rgba_t pending_pixels[$];
	int    mismatch_count = 0;
	int    pixels_checked = 0;
	int    quiet_cycles = 0;

	// Receiver behavior. stall_pct sets how often the result side stalls in
	// its normal pattern; each bump of hold_requests asks the receiver for
	// one long hold-off, which it times on its own.
	int stall_pct = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;
	int stall_run_left = 0;

	hsl_to_rgb_converter #(
		.FRAC_BITS(FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.hsl_valid(hsl_valid),
		.hsl_stall(hsl_stall),
		.hue(hue),
		.saturation(saturation),
		.lightness(lightness),
		.alpha_in(alpha_in),
		.rgb_valid(rgb_valid),
		.rgb_stall(rgb_stall),
		.red(red),
		.green(green),
		.blue(blue),
		.alpha_out(alpha_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Color prediction in fixed point.
	// ------------------------------------------------------------------

	// Rounds a product with FRAC_BITS extra fraction bits back to the unit
	// scale. Negative products cannot occur with legal operands; they give 0.
	function automatic longint round_unit(longint x);
		return (x < 0) ? 0 : ((x + HALF_FX) >>> FRAC_BITS);
	endfunction

	function automatic longint clamp_unit(longint v);
		if (v < 0)
			return 0;
		if (v > ONE_FX)
			return ONE_FX;
		return v;
	endfunction

	// Piecewise-linear HSL curve for one channel at shifted hue t: a rising
	// ramp from p to q, a flat top at q, a falling ramp back to p, then p.
	function automatic longint channel_level(longint t, longint p, longint q);
		longint d;
		d = (q > p) ? q - p : 0;
		if (t < SIXTH_FX)
			return p + round_unit(d * 6 * t);
		if (t < HALF_FX)
			return q;
		if (t < TWOTHIRDS_FX)
			return p + round_unit(d * (TWOTHIRDS_FX - t) * 6);
		return p;
	endfunction

	function automatic logic [7:0] unit_to_byte(longint v);
		longint b;
		b = round_unit(clamp_unit(v) * 255);
		if (b > 255)
			b = 255;
		return b[7:0];
	endfunction

	function automatic rgba_t hsla_to_rgba(logic [8:0] hue_deg, logic [6:0] sat_pct,
		logic [6:0] light_pct, logic [7:0] alpha);
		longint deg, sp, lp, h, s, l, q, p, t_red, t_blue;
		rgba_t px;
		// Hues past a full turn wrap once; percentages above 100 saturate.
		deg = hue_deg;
		if (deg >= HUE_SPAN)
			deg = deg - HUE_SPAN;
		sp = (sat_pct > PCT_SPAN) ? PCT_SPAN : sat_pct;
		lp = (light_pct > PCT_SPAN) ? PCT_SPAN : light_pct;
		h = (deg * ONE_FX + HUE_SPAN / 2) / HUE_SPAN;
		s = (sp * ONE_FX + PCT_SPAN / 2) / PCT_SPAN;
		l = (lp * ONE_FX + PCT_SPAN / 2) / PCT_SPAN;
		if (sp == 0) begin
			// Gray: every channel is the lightness itself.
			px.red = unit_to_byte(l);
			px.green = px.red;
			px.blue = px.red;
		end else begin
			if (l < HALF_FX)
				q = l + round_unit(l * s);
			else
				q = l + s - round_unit(l * s);
			q = clamp_unit(q);
			p = clamp_unit(2 * l - q);
			// The red hue wraps only when it passes one strictly, so a hue
			// landing exactly on one stays there and reads as p.
			t_red = h + THIRD_FX;
			if (t_red > ONE_FX)
				t_red = t_red - ONE_FX;
			t_blue = h - THIRD_FX;
			if (t_blue < 0)
				t_blue = t_blue + ONE_FX;
			px.red = unit_to_byte(channel_level(t_red, p, q));
			px.green = unit_to_byte(channel_level(h, p, q));
			px.blue = unit_to_byte(channel_level(t_blue, p, q));
		end
		px.alpha = alpha;
		return px;
	endfunction

	// ------------------------------------------------------------------
	// Request side: record every accepted request as an owed pixel.
	// Values read at the clock edge are the ones present before it, so
	// this sees exactly what the block sampled.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && hsl_valid && !hsl_stall)
			pending_pixels.push_back(hsla_to_rgba(hue, saturation, lightness, alpha_in));
	end

	// ------------------------------------------------------------------
	// Result side: each accepted result must match the oldest owed pixel.
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		mismatch_count++;
		// The count keeps going after the cap so the verdict stays honest
		// while the log stays readable.
		if (mismatch_count <= MAX_PRINTED)
			$display("%0t: mismatch: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin
		rgba_t got;
		rgba_t want;
		if (arst_n && rgb_valid && !rgb_stall) begin
			got = {red, green, blue, alpha_out};
			if (pending_pixels.size() == 0) begin
				report_mismatch($sformatf("unexpected result r=%0d g=%0d b=%0d a=%0d",
					got.red, got.green, got.blue, got.alpha));
			end else begin
				want = pending_pixels.pop_front();
				if (got.red !== want.red)
					report_mismatch($sformatf("pixel %0d red got %0d expected %0d",
						pixels_checked, got.red, want.red));
				if (got.green !== want.green)
					report_mismatch($sformatf("pixel %0d green got %0d expected %0d",
						pixels_checked, got.green, want.green));
				if (got.blue !== want.blue)
					report_mismatch($sformatf("pixel %0d blue got %0d expected %0d",
						pixels_checked, got.blue, want.blue));
				if (got.alpha !== want.alpha)
					report_mismatch($sformatf("pixel %0d alpha got %0d expected %0d",
						pixels_checked, got.alpha, want.alpha));
			end
			pixels_checked++;
		end
	end

	// ------------------------------------------------------------------
	// Receiver stall pattern. A requested hold-off takes priority and is
	// counted here; otherwise the stall level is redrawn at the end of
	// each short run of random length, so stalls come in clumps.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rgb_stall <= 1'b1;
		end else if (holds_served != hold_requests) begin
			holds_served <= holds_served + 1;
			hold_left <= HOLD_CYCLES - 1;
			rgb_stall <= 1'b1;
		end else if (stall_run_left != 0) begin
			stall_run_left <= stall_run_left - 1;
		end else begin
			rgb_stall <= ($urandom_range(99) < stall_pct);
			stall_run_left <= $urandom_range(5);
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: a long stretch with no handshake on either side means the
	// block has hung. The limit covers the longest hold-off several times.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || (hsl_valid && !hsl_stall) || (rgb_valid && !rgb_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no request or result moved for %0d cycles", $realtime, quiet_cycles);
			$display("[hsl_to_rgb_converter] ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sender primitives. Every task is entered and left just after a rising
	// edge, so all drives land as nonblocking updates at that edge. Valid
	// stays high from one request to the next inside a burst.
	// ------------------------------------------------------------------
	task automatic send_request(input logic [8:0] h, input logic [6:0] s,
		input logic [6:0] l, input logic [7:0] a);
		hsl_valid <= 1'b1;
		hue <= h;
		saturation <= s;
		lightness <= l;
		alpha_in <= a;
		// hsl_stall read right after the edge is the value the block used at it.
		do
			@(posedge clk);
		while (hsl_stall);
	endtask

	task automatic idle_cycles(input int n);
		if (n > 0) begin
			hsl_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Stops sending and waits until every owed pixel has come back. The first
	// edge lets the request monitor record a request taken at the last edge.
	task automatic wait_for_drain();
		hsl_valid <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0)
			@(posedge clk);
	endtask

	// Mostly legal colors, with a share of out-of-range hues and of
	// percentages above 100 so every input bit toggles, plus extra gray.
	task automatic send_random_request();
		logic [8:0] h;
		logic [6:0] s;
		logic [6:0] l;
		h = ($urandom_range(99) < 15) ? 9'($urandom_range(511)) : 9'($urandom_range(359));
		case ($urandom_range(9))
			0: s = '0;
			1: s = 7'($urandom_range(127));
			default: s = 7'($urandom_range(100));
		endcase
		l = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(100));
		send_request(h, s, l, 8'($urandom_range(255)));
	endtask

	// Bursts of one to sixteen requests separated by random idle gaps bounded
	// by max_gap; a zero gap merges bursts into an unbroken stream.
	task automatic random_stream(input int count, input int max_gap);
		int sent;
		int burst;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 16);
			for (int i = 0; i < burst && sent < count; i++) begin
				send_random_request();
				sent++;
			end
			idle_cycles($urandom_range(max_gap));
		end
	endtask

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// Corner colors: gray at the lightness extremes, primaries and the
	// segment edges, the hues where the red and blue shifts wrap (or just
	// fail to), hue wrap past 360, saturation and lightness clipped at 100,
	// the lightness one-half split for q, and the alpha extremes.
	task automatic test_corner_pixels();
		stall_pct = 0;
		send_request(9'd0, 7'd0, 7'd0, 8'd0);
		send_request(9'd200, 7'd0, 7'd50, 8'd128);
		send_request(9'd359, 7'd0, 7'd100, 8'd255);
		send_request(9'd0, 7'd100, 7'd50, 8'd255);
		send_request(9'd60, 7'd100, 7'd50, 8'd170);
		send_request(9'd119, 7'd100, 7'd50, 8'd85);
		send_request(9'd120, 7'd100, 7'd50, 8'd1);
		send_request(9'd180, 7'd100, 7'd50, 8'd254);
		send_request(9'd240, 7'd100, 7'd50, 8'd127);
		send_request(9'd241, 7'd100, 7'd50, 8'd128);
		send_request(9'd300, 7'd100, 7'd50, 8'd0);
		send_request(9'd359, 7'd100, 7'd50, 8'd255);
		send_request(9'd360, 7'd80, 7'd40, 8'd33);
		send_request(9'd511, 7'd80, 7'd40, 8'd66);
		send_request(9'd30, 7'd127, 7'd127, 8'd99);
		send_request(9'd90, 7'd101, 7'd101, 8'd200);
		send_request(9'd150, 7'd100, 7'd0, 8'd255);
		send_request(9'd210, 7'd100, 7'd100, 8'd255);
		send_request(9'd45, 7'd37, 7'd49, 8'd10);
		send_request(9'd45, 7'd37, 7'd50, 8'd20);
		send_request(9'd45, 7'd37, 7'd51, 8'd30);
		send_request(9'd270, 7'd1, 7'd99, 8'd240);
		wait_for_drain();
	endtask

	// Full rate with no idling on either side.
	task automatic test_back_to_back();
		stall_pct = 0;
		random_stream(300, 0);
		wait_for_drain();
	endtask

	// Bursty sender against a moderately stalling receiver; the longest idle
	// gaps outlast the pipeline, so bubbles land on every stage of it.
	task automatic test_bursty_traffic();
		stall_pct = 30;
		random_stream(900, 12);
		wait_for_drain();
	endtask

	// The receiver holds off for a long stretch while the sender keeps
	// offering requests, so the pipeline fills and stalls its input; the
	// sender then pauses until every owed pixel is back.
	task automatic test_fill_and_drain();
		stall_pct = 0;
		hold_requests++;
		random_stream(80, 0);
		wait_for_drain();
	endtask

	// Heavy back-pressure with a gappy sender.
	task automatic test_heavy_backpressure();
		stall_pct = 70;
		random_stream(500, 6);
		wait_for_drain();
	endtask

	initial begin
		// Reset is held low from the start and released at a rising edge.
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_corner_pixels();
		test_back_to_back();
		test_bursty_traffic();
		test_fill_and_drain();
		test_heavy_backpressure();
		// Give any stray extra result time to surface before the verdict.
		stall_pct = 0;
		repeat (PIPE_DEPTH + 8) @(posedge clk);
		if (mismatch_count == 0 && pending_pixels.size() == 0) begin
			$display("[hsl_to_rgb_converter] OK");
		end else begin
			$display("[hsl_to_rgb_converter] ERROR");
		end
		$finish;
	end

endmodule

// File: sim.f
src/hsl2rgb_pkg.sv
src/hsl2rgb_chan.sv
src/hsl_to_rgb_converter.sv
tb/sv/hsl_to_rgb_converter_tb.sv
